// File: design/fpalu_pkg.sv
// Shared constants, action codes and pipeline stage types of the fixed-point ALU.
`timescale 1ns / 1ps

package fpalu_pkg;

  // Fraction bits of the raw word (Q24.8 by default, legal range 0..16).
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned WORD_W    = 32;
  // Width of the scaled dividend |a| << FRAC_BITS.
  localparam int unsigned NUM_W     = WORD_W + FRAC_BITS;
  localparam int unsigned PROD_W    = 2 * WORD_W;

  // Rounding constant for the product: half of one LSB of the result.
  localparam logic [PROD_W-1:0] MUL_HALF = (PROD_W'(1) << FRAC_BITS) >> 1;

  typedef enum logic [3:0] {
    ACT_ADD     = 4'd0,
    ACT_SUB     = 4'd1,
    ACT_MUL     = 4'd2,
    ACT_DIV     = 4'd3,
    ACT_GT      = 4'd4,
    ACT_LT      = 4'd5,
    ACT_GE      = 4'd6,
    ACT_LE      = 4'd7,
    ACT_EQ      = 4'd8,
    ACT_NE      = 4'd9,
    ACT_MIN     = 4'd10,
    ACT_MAX     = 4'd11,
    ACT_INC     = 4'd12,
    ACT_TOINT   = 4'd13,
    ACT_FROMINT = 4'd14
  } action_e;

  // Payload of the front stage and of every divider step.
  typedef struct packed {
    logic [WORD_W-1:0] res;     // result of the actions other than mul/div
    logic              cmp;
    logic              dz;
    logic              is_mul;
    logic              is_div;
    logic              neg;     // sign of the mul/div result
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;   // multiplier operand and divisor
    logic [NUM_W-1:0]  numq;    // dividend shifts out, quotient shifts in
    logic [WORD_W-1:0] rem;     // partial remainder, below the divisor when the divisor is non-zero
  } item_t;

  // Payload after the multiplier stage.
  typedef struct packed {
    logic [WORD_W-1:0] res;
    logic              cmp;
    logic              dz;
    logic              is_mul;
    logic              is_arith;
    logic              neg;
    logic [PROD_W-1:0] prod;
    logic [WORD_W-1:0] quo;
    logic              rnd;
  } end1_t;

  // Payload after rounding, magnitude ready for the sign.
  typedef struct packed {
    logic [WORD_W-1:0] res;
    logic              cmp;
    logic              dz;
    logic              is_arith;
    logic              neg;
    logic [WORD_W-1:0] mag;
  } end2_t;

endpackage

// File: design/fixed_point_alu_q24_8.sv
// Top level of the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
// Every accepted input passes the front stage, the restoring divider, which resolves one
//   quotient bit per stage, the multiply, rounding and sign stages and the output register.
// Throughput: one transaction per cycle unless the output stalls; a single path keeps order.
// A stall at the output freezes all stages together; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; payload is not reset.

module fixed_point_alu_q24_8 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [3:0]                  action_i,
  input  logic signed [fpalu_pkg::WORD_W-1:0] operand_a_i,
  input  logic signed [fpalu_pkg::WORD_W-1:0] operand_b_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [fpalu_pkg::WORD_W-1:0] result_word_o,
  output logic                               compare_true_o,
  output logic                               divide_by_zero_o
);

  localparam int unsigned WORD_W = fpalu_pkg::WORD_W;
  localparam int unsigned NUM_W  = fpalu_pkg::NUM_W;
  localparam int unsigned PROD_W = fpalu_pkg::PROD_W;
  localparam int unsigned FRAC   = fpalu_pkg::FRAC_BITS;

  // Whole pipeline advances together whenever the output register is free or drained.
  logic adv;

  // Front stage (index 0) and divider steps (1..NUM_W).
  fpalu_pkg::item_t st_q   [0:NUM_W];
  logic             vld_q  [0:NUM_W];

  fpalu_pkg::item_t st0_d;

  // Rounding stages and output register.
  fpalu_pkg::end1_t e1_d, e1_q;
  fpalu_pkg::end2_t e2_d, e2_q;
  logic             e1_vld_q, e2_vld_q, out_vld_q;
  logic [WORD_W-1:0] out_res_q, out_res_d;
  logic             out_cmp_q, out_dz_q;

  logic              a_neg, b_neg;
  logic [WORD_W-1:0] ua, ub, ma, mb;
  logic              a_lt_b, a_eq_b;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // ------------------------------------------------------------------
  // Front stage: operand magnitudes, signs and all actions other than mul/div.
  // ------------------------------------------------------------------
  always_comb begin
    ua     = operand_a_i;
    ub     = operand_b_i;
    a_neg  = operand_a_i[WORD_W-1];
    b_neg  = operand_b_i[WORD_W-1];
    // Magnitude of the most negative word is 2^31, which still fits unsigned.
    ma     = a_neg ? (~ua + WORD_W'(1)) : ua;
    mb     = b_neg ? (~ub + WORD_W'(1)) : ub;
    a_lt_b = operand_a_i < operand_b_i;
    a_eq_b = ua == ub;

    st0_d        = '0;
    st0_d.mag_a  = ma;
    st0_d.mag_b  = mb;
    st0_d.neg    = a_neg ^ b_neg;
    st0_d.numq   = NUM_W'(ma) << FRAC;

    unique case (action_i)
      fpalu_pkg::ACT_ADD:     st0_d.res = ua + ub;
      fpalu_pkg::ACT_SUB:     st0_d.res = ua - ub;
      fpalu_pkg::ACT_MUL:     st0_d.is_mul = 1'b1;
      fpalu_pkg::ACT_DIV: begin
        st0_d.is_div = 1'b1;
        st0_d.dz     = (ub == '0);
      end
      fpalu_pkg::ACT_GT:      st0_d.cmp = !a_lt_b && !a_eq_b;
      fpalu_pkg::ACT_LT:      st0_d.cmp = a_lt_b;
      fpalu_pkg::ACT_GE:      st0_d.cmp = !a_lt_b;
      fpalu_pkg::ACT_LE:      st0_d.cmp = a_lt_b || a_eq_b;
      fpalu_pkg::ACT_EQ:      st0_d.cmp = a_eq_b;
      fpalu_pkg::ACT_NE:      st0_d.cmp = !a_eq_b;
      // Equal words return either operand; they are the same bits.
      fpalu_pkg::ACT_MIN:     st0_d.res = a_lt_b ? ua : ub;
      fpalu_pkg::ACT_MAX:     st0_d.res = (a_lt_b || a_eq_b) ? ub : ua;
      fpalu_pkg::ACT_INC:     st0_d.res = ua + WORD_W'(1);
      // Arithmetic shift: rounds toward minus infinity.
      fpalu_pkg::ACT_TOINT:   st0_d.res = WORD_W'(operand_a_i >>> FRAC);
      fpalu_pkg::ACT_FROMINT: st0_d.res = ua << FRAC;
      // Unused code: the result and all flags stay zero.
      default:                st0_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= st0_d;
    end
  end

  // ------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage. Every transaction
  // passes through, whatever its action; only division uses the result.
  // A zero divisor produces garbage here, which the dz flag later masks.
  // ------------------------------------------------------------------
  for (genvar k = 1; k <= NUM_W; k++) begin : g_div
    fpalu_pkg::item_t  step_d;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   rem_sub;
    logic              take;

    always_comb begin
      step_d  = st_q[k-1];
      rem_sh  = {st_q[k-1].rem, st_q[k-1].numq[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, st_q[k-1].mag_b};
      take    = rem_sh >= {1'b0, st_q[k-1].mag_b};
      step_d.numq = {st_q[k-1].numq[NUM_W-2:0], take};
      step_d.rem  = take ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= step_d;
      end
    end
  end

  // ------------------------------------------------------------------
  // Multiply stage, plus the division round-up decision: round the
  // quotient up when twice the remainder reaches the divisor.
  // ------------------------------------------------------------------
  always_comb begin
    e1_d.res      = st_q[NUM_W].res;
    e1_d.cmp      = st_q[NUM_W].cmp;
    e1_d.dz       = st_q[NUM_W].dz;
    e1_d.is_mul   = st_q[NUM_W].is_mul;
    e1_d.is_arith = st_q[NUM_W].is_mul || st_q[NUM_W].is_div;
    e1_d.neg      = st_q[NUM_W].neg;
    e1_d.prod     = PROD_W'(st_q[NUM_W].mag_a) * PROD_W'(st_q[NUM_W].mag_b);
    e1_d.quo      = st_q[NUM_W].numq[WORD_W-1:0];
    e1_d.rnd      = {st_q[NUM_W].rem, 1'b0} >= {1'b0, st_q[NUM_W].mag_b};
  end

  // ------------------------------------------------------------------
  // Rounding stage: add half an LSB and drop the fraction of the product,
  // or apply the round-up to the quotient. Only the low word is kept.
  // ------------------------------------------------------------------
  logic [PROD_W-1:0] prod_rnd;

  always_comb begin
    prod_rnd      = e1_q.prod + fpalu_pkg::MUL_HALF;
    e2_d.res      = e1_q.res;
    e2_d.cmp      = e1_q.cmp;
    e2_d.dz       = e1_q.dz;
    e2_d.is_arith = e1_q.is_arith;
    e2_d.neg      = e1_q.neg;
    e2_d.mag      = e1_q.is_mul ? prod_rnd[FRAC +: WORD_W]
                                : e1_q.quo + WORD_W'(e1_q.rnd);
  end

  // ------------------------------------------------------------------
  // Sign stage into the output register. Division by zero forces zero.
  // ------------------------------------------------------------------
  always_comb begin
    if (!e2_q.is_arith) begin
      out_res_d = e2_q.res;
    end else if (e2_q.dz) begin
      out_res_d = '0;
    end else if (e2_q.neg) begin
      out_res_d = ~e2_q.mag + WORD_W'(1);
    end else begin
      out_res_d = e2_q.mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q  <= 1'b0;
      e2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      e1_vld_q  <= vld_q[NUM_W];
      e2_vld_q  <= e1_vld_q;
      out_vld_q <= e2_vld_q;
    end
  end

  // Hold all payload while the output is stalled.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_q      <= e1_d;
      e2_q      <= e2_d;
      out_res_q <= out_res_d;
      out_cmp_q <= e2_q.cmp;
      out_dz_q  <= e2_q.dz;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign result_word_o    = out_res_q;
  assign compare_true_o   = out_cmp_q;
  assign divide_by_zero_o = out_dz_q;

endmodule

// File: dv/tb_fixed_point_alu_q24_8.sv
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 1ps

module tb_fixed_point_alu_q24_8;

  // Action code 15 lies outside the enum; the block must return an all-zero result for it.
  localparam logic [3:0]                   ACT_UNUSED = 4'd15;
  localparam logic [fpalu_pkg::WORD_W-1:0] WORD_MAX   = 32'h7fff_ffff;
  localparam logic [fpalu_pkg::WORD_W-1:0] WORD_MIN   = 32'h8000_0000;
  localparam int unsigned                  PIPE_DEPTH = fpalu_pkg::NUM_W + 4;

  // One result transaction as the block should deliver it.
  typedef struct packed {
    logic [fpalu_pkg::WORD_W-1:0] word;
    logic                         cmp;
    logic                         dz;
  } alu_result_t;

  logic                                clk_i            = 1'b0;
  logic                                rst_ni           = 1'b0;
  logic                                in_valid_i       = 1'b0;
  logic                                in_ready_o;
  logic        [3:0]                   action_i         = '0;
  logic signed [fpalu_pkg::WORD_W-1:0] operand_a_i      = '0;
  logic signed [fpalu_pkg::WORD_W-1:0] operand_b_i      = '0;
  logic                                out_valid_o;
  logic                                out_ready_i      = 1'b0;
  logic signed [fpalu_pkg::WORD_W-1:0] result_word_o;
  logic                                compare_true_o;
  logic                                divide_by_zero_o;

  alu_result_t pending_results[$];
  int          error_count  = 0;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;

  fixed_point_alu_q24_8 dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_word_o    (result_word_o),
    .compare_true_o   (compare_true_o),
    .divide_by_zero_o (divide_by_zero_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Compute the expected result of one transaction with exact 64-bit integer arithmetic.
  function automatic alu_result_t predict_alu(input logic [3:0] act,
                                              input logic signed [fpalu_pkg::WORD_W-1:0] a,
                                              input logic signed [fpalu_pkg::WORD_W-1:0] b);
    alu_result_t       r;
    longint            sa;
    longint            sb;
    longint            prod;
    longint unsigned   mag;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   quo;
    longint unsigned   half;
    r    = '0;
    sa   = longint'(a);
    sb   = longint'(b);
    half = (64'd1 << fpalu_pkg::FRAC_BITS) >> 1;
    case (act)
      fpalu_pkg::ACT_ADD: r.word = a + b;
      fpalu_pkg::ACT_SUB: r.word = a - b;
      fpalu_pkg::ACT_MUL: begin
        // Round the magnitude half away from zero, then restore the sign and wrap.
        prod   = sa * sb;
        mag    = (prod < 0) ? -prod : prod;
        mag    = (mag + half) >> fpalu_pkg::FRAC_BITS;
        r.word = fpalu_pkg::WORD_W'((prod < 0) ? -mag : mag);
      end
      fpalu_pkg::ACT_DIV: begin
        if (sb == 0) begin
          r.dz = 1'b1;
        end else begin
          num    = ((sa < 0) ? -sa : sa);
          num    = num << fpalu_pkg::FRAC_BITS;
          den    = (sb < 0) ? -sb : sb;
          // (2n + d) / 2d rounds the quotient magnitude to nearest, halves upwards.
          quo    = (2 * num + den) / (2 * den);
          r.word = fpalu_pkg::WORD_W'(((sa < 0) != (sb < 0)) ? -quo : quo);
        end
      end
      fpalu_pkg::ACT_GT:      r.cmp  = (a > b);
      fpalu_pkg::ACT_LT:      r.cmp  = (a < b);
      fpalu_pkg::ACT_GE:      r.cmp  = (a >= b);
      fpalu_pkg::ACT_LE:      r.cmp  = (a <= b);
      fpalu_pkg::ACT_EQ:      r.cmp  = (a == b);
      fpalu_pkg::ACT_NE:      r.cmp  = (a != b);
      fpalu_pkg::ACT_MIN:     r.word = (a >= b) ? b : a;
      fpalu_pkg::ACT_MAX:     r.word = (a <= b) ? b : a;
      fpalu_pkg::ACT_INC:     r.word = a + 1;
      fpalu_pkg::ACT_TOINT:   r.word = a >>> fpalu_pkg::FRAC_BITS;
      fpalu_pkg::ACT_FROMINT: r.word = a << fpalu_pkg::FRAC_BITS;
      default: ;
    endcase
    return r;
  endfunction

  // Bias operands towards the word extremes, zero and small fixed-point values.
  function automatic logic [fpalu_pkg::WORD_W-1:0] pick_operand();
    logic [fpalu_pkg::WORD_W-1:0] v;
    case ($urandom_range(7))
      0: v = WORD_MAX;
      1: v = WORD_MIN;
      2: v = $urandom_range(0, 2047) - 1024;
      3: begin
        v = $urandom & 32'h000f_ffff;
        if ($urandom_range(1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offer one transaction, idling first at the current sender rate; hold it until accepted.
  task automatic send_item(input logic [3:0] act, input logic [fpalu_pkg::WORD_W-1:0] a,
                           input logic [fpalu_pkg::WORD_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_alu(act, a, b));
  endtask

  task automatic send_random_item();
    logic [3:0]                   act;
    logic [fpalu_pkg::WORD_W-1:0] a;
    logic [fpalu_pkg::WORD_W-1:0] b;
    act = 4'($urandom_range(15));
    a   = pick_operand();
    // Equal operands and zero divisors need a push to turn up often enough.
    case ($urandom_range(7))
      0:       b = a;
      1:       b = '0;
      default: b = pick_operand();
    endcase
    send_item(act, a, b);
  endtask

  // Drop valid and hold off until every outstanding result has been checked.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_random_item();
    wait_for_results();
  endtask

  // Corners: wrap-around, rounding of halves, zero divisor, equal operands, unused code.
  task automatic test_directed_corners();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_item(fpalu_pkg::ACT_ADD,     WORD_MAX,      32'd1);
    send_item(fpalu_pkg::ACT_ADD,     WORD_MIN,      WORD_MIN);
    send_item(fpalu_pkg::ACT_SUB,     WORD_MIN,      32'd1);
    send_item(fpalu_pkg::ACT_MUL,     WORD_MAX,      WORD_MAX);
    send_item(fpalu_pkg::ACT_MUL,     WORD_MIN,      WORD_MIN);
    send_item(fpalu_pkg::ACT_MUL,     32'd1,         32'd128);
    send_item(fpalu_pkg::ACT_MUL,     32'hffff_ffff, 32'd128);
    send_item(fpalu_pkg::ACT_MUL,     32'h0000_0180, 32'hffff_fe00);
    send_item(fpalu_pkg::ACT_DIV,     32'h0000_0500, 32'd0);
    send_item(fpalu_pkg::ACT_DIV,     WORD_MIN,      32'hffff_ffff);
    send_item(fpalu_pkg::ACT_DIV,     32'd1,         32'd512);
    send_item(fpalu_pkg::ACT_DIV,     32'hffff_ffff, 32'd512);
    send_item(fpalu_pkg::ACT_GT,      WORD_MIN,      WORD_MAX);
    send_item(fpalu_pkg::ACT_LT,      WORD_MIN,      WORD_MAX);
    send_item(fpalu_pkg::ACT_GE,      32'd7,         32'd7);
    send_item(fpalu_pkg::ACT_LE,      WORD_MAX,      WORD_MIN);
    send_item(fpalu_pkg::ACT_EQ,      WORD_MIN,      WORD_MIN);
    send_item(fpalu_pkg::ACT_NE,      32'd0,         32'd1);
    send_item(fpalu_pkg::ACT_MIN,     WORD_MIN,      WORD_MAX);
    send_item(fpalu_pkg::ACT_MAX,     32'hffff_fffb, 32'hffff_fffb);
    send_item(fpalu_pkg::ACT_INC,     WORD_MAX,      WORD_MIN);
    send_item(fpalu_pkg::ACT_TOINT,   32'hffff_ffff, 32'd0);
    send_item(fpalu_pkg::ACT_TOINT,   WORD_MIN,      WORD_MAX);
    send_item(fpalu_pkg::ACT_FROMINT, WORD_MAX,      32'd0);
    send_item(ACT_UNUSED,             WORD_MAX,      WORD_MAX);
    wait_for_results();
  endtask

  task automatic test_random_no_idle();
    run_random_phase(430, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_phase(430, 65, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_phase(430, 0, 65);
  endtask

  task automatic test_random_both_idle();
    run_random_phase(430, 35, 35);
  endtask

  // Hold the output off well past the pipeline depth while the sender keeps offering,
  // so the stages fill and the input stalls.
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (4 * PIPE_DEPTH) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (120) send_random_item();
      end
    join
    wait_for_results();
  endtask

  // Receiver: stall at the current rate, or hold off completely during a pressure stretch.
  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Check every accepted result transaction against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: result_word %h", result_word_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_word_o !== want.word) begin
          $error("result_word mismatch: expected %h, actual %h", want.word, result_word_o);
          error_count++;
        end
        if (compare_true_o !== want.cmp) begin
          $error("compare_true mismatch: expected %b, actual %b", want.cmp, compare_true_o);
          error_count++;
        end
        if (divide_by_zero_o !== want.dz) begin
          $error("divide_by_zero mismatch: expected %b, actual %b", want.dz, divide_by_zero_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_no_idle();
    test_random_sender_idle();
    test_output_backpressure();
    test_random_receiver_stall();
    test_random_both_idle();

    // Allow any stray result to surface before the verdict.
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("fixed_point_alu_q24_8 verification clean");
    end else begin
      $display("fixed_point_alu_q24_8 verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("fixed_point_alu_q24_8 verification failed");
    $finish;
  end

endmodule
